/* design/apsp_pkg.sv */
// Package for the actuator position and speed profile core.
// Holds item structs, arithmetic constants and the microcode word format.
// No dependencies.
package apsp_pkg;

    // Sample width of the potentiometer converter
    localparam int ADC_BITS = 10;
    // Width that holds both the raw sample and the clip level
    localparam int SAMP_W   = (ADC_BITS > 10) ? ADC_BITS : 10;

    localparam logic [SAMP_W-1:0] SAMPLE_CLIP = SAMP_W'(850);
    localparam logic [10:0]       SAMPLE_LOW  = 11'd50;
    localparam logic [8:0]        BASE_DRIVE  = 9'd50;
    localparam logic [8:0]        DRIVE_MAX   = 9'd255;
    localparam logic [6:0]        FACTOR_NUM  = 7'd97;
    localparam logic [6:0]        FACTOR_DEN  = 7'd100;

    // Divider: 31-bit dividend, one quotient bit per step
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = 5;

    // Step counter width of the microprogram
    localparam int STEP_W = 4;

    typedef struct packed {
        logic [ADC_BITS-1:0] sensor_sample;
        logic [6:0]          target_position;
        logic [7:0]          peak_speed;
    } t_in_item;

    typedef struct packed {
        logic [7:0] drive_extend_pwm;
        logic [7:0] drive_retract_pwm;
        logic       move_active;
    } t_out_item;

    // Datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP   = 4'd0;
    localparam t_op OP_LOAD  = 4'd1;
    localparam t_op OP_MID   = 4'd2;
    localparam t_op OP_SQ    = 4'd3;
    localparam t_op OP_DINIT = 4'd4;
    localparam t_op OP_DSTEP = 4'd5;
    localparam t_op OP_COEF  = 4'd6;
    localparam t_op OP_MUL   = 4'd7;
    localparam t_op OP_OUT   = 4'd8;

    // Sequencing conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEXT     = 3'd0;
    localparam t_cond C_JUMP     = 3'd1;
    localparam t_cond C_WAIT_IN  = 3'd2;
    localparam t_cond C_IF_MOVE  = 3'd3;
    localparam t_cond C_LOOP     = 3'd4;
    localparam t_cond C_WAIT_OUT = 3'd5;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // Control word as seen by the datapath
    typedef struct packed {
        t_op  op;
        logic en;
    } t_cmd;

    // Datapath status as seen by the sequencer
    typedef struct packed {
        logic moving;
        logic cnt_zero;
        logic out_busy;
    } t_stat;

endpackage

/* design/apsp_sequencer.sv */
// Microcode sequencer: program ROM, step counter and jump logic.
// Depends on apsp_pkg.
module apsp_sequencer import apsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;
    logic              w_en;

    // Program ROM
    function automatic t_ctrl rom(input logic [STEP_W-1:0] step);
        t_ctrl c;
        unique case (step)
            4'd0:    c = '{op: OP_LOAD,  cond: C_WAIT_IN,  target: 4'd0};
            4'd1:    c = '{op: OP_NOP,   cond: C_IF_MOVE,  target: 4'd7};
            4'd2:    c = '{op: OP_MID,   cond: C_NEXT,     target: 4'd0};
            4'd3:    c = '{op: OP_SQ,    cond: C_NEXT,     target: 4'd0};
            4'd4:    c = '{op: OP_DINIT, cond: C_NEXT,     target: 4'd0};
            4'd5:    c = '{op: OP_DSTEP, cond: C_LOOP,     target: 4'd5};
            4'd6:    c = '{op: OP_COEF,  cond: C_NEXT,     target: 4'd0};
            4'd7:    c = '{op: OP_SQ,    cond: C_NEXT,     target: 4'd0};
            4'd8:    c = '{op: OP_MUL,   cond: C_NEXT,     target: 4'd0};
            4'd9:    c = '{op: OP_OUT,   cond: C_WAIT_OUT, target: 4'd0};
            default: c = '{op: OP_NOP,   cond: C_JUMP,     target: 4'd0};
        endcase
        return c;
    endfunction

    assign w_ctrl = rom(r_step);

    // Pick the next step and whether this step's operation commits
    always_comb begin
        w_en   = 1'b1;
        n_step = r_step + 1'b1;
        unique case (w_ctrl.cond)
            C_NEXT: begin
                n_step = r_step + 1'b1;
            end
            C_JUMP: begin
                n_step = w_ctrl.target;
            end
            C_WAIT_IN: begin
                w_en   = i_in_valid;
                n_step = i_in_valid ? r_step + 1'b1 : r_step;
            end
            C_IF_MOVE: begin
                n_step = i_stat.moving ? w_ctrl.target : r_step + 1'b1;
            end
            C_LOOP: begin
                n_step = i_stat.cnt_zero ? r_step + 1'b1 : w_ctrl.target;
            end
            C_WAIT_OUT: begin
                w_en   = !i_stat.out_busy;
                n_step = i_stat.out_busy ? r_step : w_ctrl.target;
            end
            default: begin
                n_step = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_cmd      = '{op: w_ctrl.op, en: w_en};
    assign o_in_ready = (w_ctrl.cond == C_WAIT_IN);

endmodule

/* design/apsp_datapath.sv */
// Datapath: position scaling, profile setup, divider, square and drive level.
// Depends on apsp_pkg; driven by apsp_sequencer control words.
module apsp_datapath import apsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_item,
    input  logic      i_out_ready,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    logic signed [7:0]  r_pos;
    logic [6:0]         r_tgt;
    logic [7:0]         r_spd;
    logic signed [7:0]  r_mid;
    logic [13:0]        r_sq;
    logic [20:0]        r_div;
    logic [20:0]        r_rem;
    logic [30:0]        r_num;
    logic [CNT_W-1:0]   r_cnt;
    logic [23:0]        r_coef;
    logic [37:0]        r_prod;
    logic               r_move;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [SAMP_W-1:0]  w_samp;
    logic [SAMP_W-1:0]  w_clip;
    logic signed [10:0] w_x;
    logic signed [10:0] w_xb;
    logic signed [7:0]  w_pos;
    logic signed [8:0]  w_sum;
    logic signed [8:0]  w_sumb;
    logic signed [8:0]  w_e;
    logic signed [17:0] w_e2;
    logic [21:0]        w_trial;
    logic               w_ge;
    logic [21:0]        w_diff;
    logic [27:0]        w_div100;
    logic [14:0]        w_num97;
    logic [24:0]        w_top;
    logic [24:0]        w_left;
    logic [8:0]         w_lvl9;
    logic [7:0]         w_lvl;
    logic signed [7:0]  w_tgt_s;
    logic               w_go;

    // Clip the sample and scale to percent, truncating toward zero
    assign w_samp = SAMP_W'(i_item.sensor_sample);
    assign w_clip = (w_samp > SAMPLE_CLIP) ? SAMPLE_CLIP : w_samp;
    assign w_x    = $signed({1'b0, w_clip[9:0]}) - $signed(SAMPLE_LOW);
    assign w_xb   = w_x + (w_x[10] ? 11'sd7 : 11'sd0);
    assign w_pos  = 8'(w_xb >>> 3);

    // Midpoint of start and target, truncating toward zero
    assign w_sum  = 9'(r_pos) + $signed({2'b00, r_tgt});
    assign w_sumb = w_sum + (w_sum[8] ? 9'sd1 : 9'sd0);

    // Offset from the midpoint and its square
    assign w_e  = 9'(r_pos) - 9'(r_mid);
    assign w_e2 = w_e * w_e;

    // One restoring divide step
    assign w_trial = {r_rem, r_num[30]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    assign w_div100 = r_sq * {7'd0, FACTOR_DEN};
    assign w_num97  = r_spd * {8'd0, FACTOR_NUM};

    // Drive level: top minus parabola drop, clamped to 0..255
    assign w_top  = {({1'b0, r_spd} + BASE_DRIVE), 16'd0};
    assign w_left = w_top - r_prod[24:0];
    assign w_lvl9 = (r_prod >= {13'd0, w_top}) ? 9'd0 : w_left[24:16];
    assign w_lvl  = (w_lvl9 > DRIVE_MAX) ? 8'hFF : w_lvl9[7:0];

    assign w_tgt_s = $signed({1'b0, r_tgt});

    assign w_go = i_cmd.en;

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_pos <= w_pos;
                    r_tgt <= i_item.target_position;
                    r_spd <= i_item.peak_speed;
                end
                OP_SQ: begin
                    r_sq <= w_e2[13:0];
                end
                OP_DINIT: begin
                    r_div <= w_div100[20:0];
                    r_num <= {w_num97, 16'd0};
                    r_rem <= '0;
                    r_cnt <= CNT_W'(DIV_STEPS - 1);
                end
                OP_DSTEP: begin
                    r_rem <= w_ge ? w_diff[20:0] : w_trial[20:0];
                    r_num <= {r_num[29:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                OP_MUL: begin
                    r_prod <= r_coef * {24'd0, r_sq};
                end
                OP_OUT: begin
                    if (r_pos < w_tgt_s) begin
                        r_out <= '{drive_extend_pwm: w_lvl, drive_retract_pwm: 8'd0,
                                   move_active: 1'b1};
                    end else if (r_pos > w_tgt_s) begin
                        r_out <= '{drive_extend_pwm: 8'd0, drive_retract_pwm: w_lvl,
                                   move_active: 1'b1};
                    end else begin
                        r_out <= '{drive_extend_pwm: 8'd0, drive_retract_pwm: 8'd0,
                                   move_active: 1'b0};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Profile state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move      <= 1'b0;
            r_coef      <= '0;
            r_mid       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go && i_cmd.op == OP_MID) begin
                r_mid <= w_sumb[8:1];
            end
            if (w_go && i_cmd.op == OP_COEF) begin
                r_coef <= (r_sq == '0) ? 24'd0 : r_num[23:0];
                r_move <= 1'b1;
            end
            if (w_go && i_cmd.op == OP_OUT) begin
                if (r_pos == w_tgt_s) begin
                    r_move <= 1'b0;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat = '{moving:   r_move,
                      cnt_zero: (r_cnt == '0),
                      out_busy: r_out_valid && !i_out_ready};

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* design/actuator_position_speed_profile_core.sv */
// Actuator position and speed profile core: top level.
// Input channel (i_valid/o_ready, i_data) takes one item per control tick:
// potentiometer sample, target position in percent and peak speed.
// Output channel (o_valid/i_ready, o_data) gives one item per input item:
// extend and retract PWM duties and the move-active flag.
// A microcoded sequencer steps a shared datapath; the divider takes one
// quotient bit per cycle.
// An accepted item passes the move check, square, multiply and output steps
// while a move is in progress; on the first tick of a move the midpoint,
// square, divider setup, divide loop and coefficient steps come first. The next
// item is taken while the previous result still waits in the output register.
// When the receiver stalls, the result holds in the output register and the
// sequencer waits at its final step until the register frees up.
// Reset (i_rst_n low, synchronous) ends any move, clears the coefficient and
// midpoint, drops o_valid and returns the sequencer to its load step.
// Depends on apsp_pkg, apsp_sequencer and apsp_datapath.
module actuator_position_speed_profile_core import apsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    apsp_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_ready)
    );

    apsp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_data),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .o_out_item  (o_data)
    );

endmodule
